// ===== sv/tbpd_pkg.sv =====
// Shared constants and types of the tagged byte-pair deframer.
package tbpd_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned WORD_W          = 16;
    localparam int unsigned INDEX_W         = 4;
    localparam int unsigned M_TDATA_W       = 24;
    localparam int unsigned WORDS_PER_FRAME = 12;

    localparam logic [BYTE_W-1:0] TAG_BASE_RESET = 8'd97;

    // One finished word on its way to the output register
    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               last;
    } word_t;

endpackage

// ===== sv/tbpd_in_stage.sv =====
// Input register of the deframer: holds one received byte for the parser.
module tbpd_in_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tbpd_pkg::BYTE_W-1:0] s_tdata,
    input  logic                      take,
    output logic                      byte_valid,
    output logic [tbpd_pkg::BYTE_W-1:0] rx_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [tbpd_pkg::BYTE_W-1:0] byte_reg;

    // free slot, or the held byte leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

// ===== sv/tbpd_parse.sv =====
// Tag hunt and byte-pair assembly: frame state, tag base and word counter.
module tbpd_parse #(
    parameter int unsigned WORDS_PER_FRAME = tbpd_pkg::WORDS_PER_FRAME
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_valid,
    input  logic [tbpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        out_room,
    input  logic                        cfg_we,
    input  logic [tbpd_pkg::BYTE_W-1:0] cfg_wdata,
    output logic                        take,
    output logic                        word_valid,
    output tbpd_pkg::word_t             word
);

    localparam int unsigned CNT_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORDS_PER_FRAME - 1);

    logic [tbpd_pkg::BYTE_W-1:0] tag_base_reg,  tag_base_next;
    logic [tbpd_pkg::BYTE_W-1:0] exp_tag_reg,   exp_tag_next;
    logic                        awaiting_reg,  awaiting_next;
    logic                        high_half_reg, high_half_next;
    logic [tbpd_pkg::BYTE_W-1:0] low_hold_reg,  low_hold_next;
    logic [CNT_W-1:0]            cnt_reg,       cnt_next;

    logic                        completes;
    logic                        is_last;
    logic                        at_start;
    logic [CNT_W+3:0]            cnt_ext;

    assign completes = awaiting_reg && high_half_reg;
    assign is_last   = (cnt_reg == LAST_CNT);
    assign at_start  = !awaiting_reg && !high_half_reg && (cnt_reg == '0);

    // a byte that finishes a word needs space downstream; all others pass
    assign take       = byte_valid && (!completes || out_room);
    assign word_valid = take && completes;

    assign cnt_ext     = {4'b0000, cnt_reg};
    assign word.value  = {rx_byte, low_hold_reg};
    assign word.index  = cnt_ext[tbpd_pkg::INDEX_W-1:0];
    assign word.last   = is_last;

    always_comb begin
        tag_base_next  = cfg_we ? cfg_wdata : tag_base_reg;
        exp_tag_next   = exp_tag_reg;
        awaiting_next  = awaiting_reg;
        high_half_next = high_half_reg;
        low_hold_next  = low_hold_reg;
        cnt_next       = cnt_reg;
        if (take) begin
            if (!awaiting_reg) begin
                if (rx_byte == exp_tag_reg) begin
                    awaiting_next = 1'b1;
                end
            end else begin
                awaiting_next = 1'b0;
                exp_tag_next  = exp_tag_reg + 8'd1;
                if (!high_half_reg) begin
                    low_hold_next  = rx_byte;
                    high_half_next = 1'b1;
                end else begin
                    high_half_next = 1'b0;
                    if (is_last) begin
                        cnt_next     = '0;
                        exp_tag_next = tag_base_reg;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
        end else if (cfg_we && at_start) begin
            exp_tag_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_base_reg  <= tbpd_pkg::TAG_BASE_RESET;
            exp_tag_reg   <= tbpd_pkg::TAG_BASE_RESET;
            awaiting_reg  <= 1'b0;
            high_half_reg <= 1'b0;
            low_hold_reg  <= '0;
            cnt_reg       <= '0;
        end else begin
            tag_base_reg  <= tag_base_next;
            exp_tag_reg   <= exp_tag_next;
            awaiting_reg  <= awaiting_next;
            high_half_reg <= high_half_next;
            low_hold_reg  <= low_hold_next;
            cnt_reg       <= cnt_next;
        end
    end

    // word counter never passes the last word of a frame
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_CNT)
        else $error("word counter out of range");

    // a finished word is never pushed into a full, stalled output register
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        word_valid |-> out_room)
        else $error("word issued without output space");

    // last word rearms to the base tag and clears the counter
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_valid && is_last) |=>
            (exp_tag_reg == $past(tag_base_reg)) && (cnt_reg == '0) && at_start)
        else $error("frame end did not rearm");

    // a skipped byte while hunting leaves the expected tag alone
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !awaiting_reg && (rx_byte != exp_tag_reg)) |=>
            $stable(exp_tag_reg) && !awaiting_reg)
        else $error("skipped byte changed hunt state");

endmodule

// ===== sv/tbpd_out_stage.sv =====
// Output register of the deframer: holds one finished word until taken.
module tbpd_out_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            word_valid,
    input  tbpd_pkg::word_t word,
    output logic            out_room,
    output logic            m_tvalid,
    input  logic            m_tready,
    output tbpd_pkg::word_t m_word
);

    logic            valid_reg;
    logic            valid_next;
    tbpd_pkg::word_t word_reg;

    assign out_room   = !valid_reg || m_tready;
    assign valid_next = out_room ? word_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_valid && out_room) begin
            word_reg <= word;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_word   = word_reg;

endmodule

// ===== sv/tagged_byte_pair_deframer.sv =====
// Top level of the tagged byte-pair deframer: byte stream in, tagged words out.
//
//   Channel  Direction  Transaction contents
//   s_       in         tdata[7:0] = rx_byte (tag or data byte)
//   m_       out        tdata[15:0] = word_value, tdata[19:16] = word_index, tlast = last_word
//   cfg_     in         cfg_wdata = tag_base, written when cfg_we is high
//
// One byte transaction is accepted per cycle, sustained while the output register
// has room for each finished word. A byte passes the input register, the tag/pair
// logic and the output register; m_tvalid for a word rises when the output
// register takes the word of its high data byte. Reset is synchronous on aresetn
// low; it rearms the hunt at tag 97 and empties both registers. A stalled m_ side
// holds one word in the output register and one byte in the input register; bytes
// that complete no word keep flowing during the stall.
module tagged_byte_pair_deframer #(
    parameter int unsigned WORDS_PER_FRAME = tbpd_pkg::WORDS_PER_FRAME
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave side: byte stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tbpd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // master side: assembled words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tbpd_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] word_value, [19:16] word_index, [23:20] zero
    output logic                           m_tlast,   // last_word
    // tag base register
    input  logic                           cfg_we,
    input  logic [tbpd_pkg::BYTE_W-1:0]    cfg_wdata
);

    logic                        take;
    logic                        byte_valid;
    logic [tbpd_pkg::BYTE_W-1:0] rx_byte;
    logic                        out_room;
    logic                        word_valid;
    tbpd_pkg::word_t             word;
    tbpd_pkg::word_t             m_word;

    // input register
    tbpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    // tag hunt, pair assembly, frame counting
    tbpd_parse #(
        .WORDS_PER_FRAME (WORDS_PER_FRAME)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .out_room   (out_room),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    // output register
    tbpd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word       (word),
        .out_room   (out_room),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_word     (m_word)
    );

    // pack word fields, lowest first, padded to three bytes
    assign m_tdata = {4'b0000, m_word.index, m_word.value};
    assign m_tlast = m_word.last;

endmodule

// ===== tb/tbpd_word_checker.sv =====
`timescale 1ns / 100ps
// Word checker for the tagged byte-pair deframer: predicts words from bytes and compares.
module tbpd_word_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tbpd_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tbpd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [tbpd_pkg::BYTE_W-1:0]    cfg_wdata,
    output int                             fail_count,
    output int                             words_waiting,
    output int                             words_checked,
    output int                             frames_closed
);

    // Deframer state as seen from the byte stream
    logic [tbpd_pkg::BYTE_W-1:0] tag_base_q = tbpd_pkg::TAG_BASE_RESET;
    logic [tbpd_pkg::BYTE_W-1:0] hunt_tag   = tbpd_pkg::TAG_BASE_RESET;
    logic                        data_next  = 1'b0;
    logic                        high_next  = 1'b0;
    logic [tbpd_pkg::BYTE_W-1:0] low_hold   = '0;
    int unsigned                 word_cnt   = 0;

    tbpd_pkg::word_t assembled_words[$];
    int n_fail   = 0;
    int n_words  = 0;
    int n_frames = 0;

    // Advance the hunt/pair state by one byte; a finished word is queued.
    task automatic take_rx_byte(input logic [tbpd_pkg::BYTE_W-1:0] b);
        tbpd_pkg::word_t w;
        if (!data_next) begin
            if (b == hunt_tag) data_next = 1'b1;
        end else begin
            data_next = 1'b0;
            hunt_tag  = hunt_tag + 8'd1;
            if (!high_next) begin
                low_hold  = b;
                high_next = 1'b1;
            end else begin
                high_next = 1'b0;
                w.value = {b, low_hold};
                w.index = word_cnt[tbpd_pkg::INDEX_W-1:0];
                w.last  = (word_cnt + 1 >= tbpd_pkg::WORDS_PER_FRAME);
                if (w.last) begin
                    word_cnt = 0;
                    hunt_tag = tag_base_q;
                end else begin
                    word_cnt++;
                end
                assembled_words.push_back(w);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        tbpd_pkg::word_t got;
        tbpd_pkg::word_t want;
        if (!aresetn) begin
            tag_base_q = tbpd_pkg::TAG_BASE_RESET;
            hunt_tag   = tbpd_pkg::TAG_BASE_RESET;
            data_next  = 1'b0;
            high_next  = 1'b0;
            low_hold   = '0;
            word_cnt   = 0;
            assembled_words.delete();
        end else begin
            // new base reloads the hunt only at the very start of a frame
            if (cfg_we) begin
                tag_base_q = cfg_wdata;
                if (!data_next && !high_next && word_cnt == 0) hunt_tag = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[tbpd_pkg::WORD_W-1:0];
                got.index = m_tdata[tbpd_pkg::WORD_W +: tbpd_pkg::INDEX_W];
                got.last  = m_tlast;
                if (assembled_words.size() == 0) begin
                    $error("unpredicted word: value %h index %0d last %0b",
                           got.value, got.index, got.last);
                    n_fail++;
                end else begin
                    want = assembled_words.pop_front();
                    n_words++;
                    if (want.last) n_frames++;
                    if (got.value !== want.value) begin
                        $error("word_value: expected %h, got %h", want.value, got.value);
                        n_fail++;
                    end
                    if (got.index !== want.index) begin
                        $error("word_index: expected %0d, got %0d", want.index, got.index);
                        n_fail++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_word: expected %0b, got %0b", want.last, got.last);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready) take_rx_byte(s_tdata);
        end
        fail_count    <= n_fail;
        words_waiting <= assembled_words.size();
        words_checked <= n_words;
        frames_closed <= n_frames;
    end

endmodule

// ===== tb/tagged_byte_pair_deframer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the tagged byte-pair deframer: byte stimulus, tag base writes, verdict.
module tagged_byte_pair_deframer_tb;

    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 4;     // byte path is two registers deep
    localparam int PHASE_BYTES  = 180;
    localparam int N_PHASES     = 6;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tbpd_pkg::BYTE_W-1:0]    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tbpd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [tbpd_pkg::BYTE_W-1:0]    cfg_wdata = '0;

    int fail_count;
    int words_waiting;
    int words_checked;
    int frames_closed;

    int s_idle_pct   = 0;
    int m_idle_pct   = 0;
    int bytes_sent   = 0;
    int stall_cycles = 0;

    // Sender's own view of the hunt, used only to steer the stream toward
    // well-formed frames (right tag when hunting, data right after a tag).
    logic [tbpd_pkg::BYTE_W-1:0] link_base    = tbpd_pkg::TAG_BASE_RESET;
    logic [tbpd_pkg::BYTE_W-1:0] link_tag     = tbpd_pkg::TAG_BASE_RESET;
    logic                        link_in_data = 1'b0;
    logic                        link_high    = 1'b0;
    int                          link_words   = 0;

    // Opening bytes at the reset base 'a': junk and an out-of-order tag while
    // hunting, data bytes equal to tags, 00/FF in both halves, a stale tag
    // skipped between the halves of a pair.
    logic [tbpd_pkg::BYTE_W-1:0] opening [24] = '{
        8'h00, 8'hFF, 8'h62,                // skipped while hunting for 'a'
        8'h61, 8'h61, 8'h62, 8'h62,         // data equal to tag values
        8'h63, 8'h00, 8'h64, 8'hFF,         // low 00, high FF
        8'h65, 8'hFF, 8'h66, 8'h00,         // low FF, high 00
        8'h67, 8'h66, 8'h67, 8'h68, 8'h68,  // stale tag between halves
        8'h69, 8'h69, 8'h6A, 8'hA5
    };

    tagged_byte_pair_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tbpd_word_checker word_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .words_waiting (words_waiting),
        .words_checked (words_checked),
        .frames_closed (frames_closed)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver backpressure; m_idle_pct = 0 means always ready
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Watchdog: a stall counter, cleared by any transaction on either side,
    // ends the run as a failure when it would reach STALL_LIMIT.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // True when no tag is matched and no word is begun in the current frame
    function automatic logic link_at_start();
        return !link_in_data && !link_high && link_words == 0;
    endfunction

    // Offer one byte, with random sender gaps, and hold it until accepted.
    // The link view follows the byte once the transaction completes.
    task automatic send_byte(input logic [tbpd_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (!link_in_data) begin
            if (b == link_tag) link_in_data = 1'b1;
        end else begin
            link_in_data = 1'b0;
            link_tag     = link_tag + 8'd1;
            if (!link_high) begin
                link_high = 1'b1;
            end else begin
                link_high = 1'b0;
                if (link_words + 1 >= tbpd_pkg::WORDS_PER_FRAME) begin
                    link_words = 0;
                    link_tag   = link_base;
                end else begin
                    link_words++;
                end
            end
        end
    endtask

    // Mostly well-formed: the expected tag when hunting, biased data after it.
    // The rest is junk or the next tag out of order, both skipped by the hunt.
    task automatic send_link_byte();
        logic [tbpd_pkg::BYTE_W-1:0] b;
        int unsigned roll;
        roll = $urandom_range(99);
        if (link_in_data) begin
            if (roll < 10)      b = 8'h00;
            else if (roll < 20) b = 8'hFF;
            else if (roll < 30) b = link_tag;   // data that looks like a tag
            else                b = 8'($urandom_range(255));
        end else begin
            if (roll < 82)      b = link_tag;
            else if (roll < 88) b = link_tag + 8'd1;
            else                b = 8'($urandom_range(255));
        end
        send_byte(b);
    endtask

    // Tag base write with the block idle: every predicted word delivered and
    // the byte pipeline given time to empty.
    task automatic write_tag_base(input logic [tbpd_pkg::BYTE_W-1:0] v);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        link_base = v;
        if (link_at_start()) link_tag = v;
    endtask

    initial begin : stimulus
        logic [tbpd_pkg::BYTE_W-1:0] bases [N_PHASES];
        int n;
        // 255 and 250 make the tags of a frame wrap through zero
        bases = '{8'd0, 8'd255, 8'd250, 8'd0, 8'd97, 8'd3};
        bases[3] = 8'($urandom_range(255));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        s_idle_pct = 23;
        m_idle_pct = 60;
        foreach (opening[i]) send_byte(opening[i]);

        // Idle mixes: sender light / receiver heavy, swapped, then none.
        // Even phases stop on a frame boundary so the next base write loads at once;
        // odd phases stop wherever their byte count ends, so it may wait for the rearm.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 2) begin
                s_idle_pct = 60;
                m_idle_pct = 23;
            end
            if (ph == 4) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            write_tag_base(bases[ph]);
            n = 0;
            while (n < PHASE_BYTES || (ph % 2 == 0 && !link_at_start())) begin
                send_link_byte();
                n++;
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_waiting != 0);
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d byte transactions, %0d words checked, %0d frame ends.",
                 bytes_sent, words_checked, frames_closed);
        $display("Summary: %0d tag base writes (0, 255, wrapping 250, random), three idle mixes.",
                 N_PHASES);
        if (fail_count == 0 && words_waiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
